FILE: sv/ror_pkg.sv
// Shared types and constants for the rectangle overlap ratio block.
package ror_pkg;

   localparam int COORD_BITS  = 12;
   localparam int AREA_BITS   = 2 * COORD_BITS;
   localparam int FRAC_BITS   = 16;
   localparam int RATIO_BITS  = FRAC_BITS + 1;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [RATIO_BITS-1:0] RATIO_ONE_FIXED = {1'b1, {FRAC_BITS{1'b0}}};

   typedef enum logic [1:0] {
      RATIO_DIVIDE,
      RATIO_FORCE_ONE,
      RATIO_FORCE_ZERO
   } ratio_sel_type;

   typedef struct packed {
      logic                  mode;
      logic [COORD_BITS-1:0] first_left;
      logic [COORD_BITS-1:0] first_top;
      logic [COORD_BITS-1:0] first_width;
      logic [COORD_BITS-1:0] first_height;
      logic [COORD_BITS-1:0] second_left;
      logic [COORD_BITS-1:0] second_top;
      logic [COORD_BITS-1:0] second_width;
      logic [COORD_BITS-1:0] second_height;
   } req_word_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] meet_left;
      logic [COORD_BITS-1:0] meet_top;
      logic [COORD_BITS-1:0] meet_width;
      logic [COORD_BITS-1:0] meet_height;
      logic [RATIO_BITS-1:0] area_ratio;
   } rsp_word_type;

   // Classified word handed from the front end to the divider.
   typedef struct packed {
      logic [COORD_BITS-1:0] meet_left;
      logic [COORD_BITS-1:0] meet_top;
      logic [COORD_BITS-1:0] meet_width;
      logic [COORD_BITS-1:0] meet_height;
      ratio_sel_type         sel;
      logic [AREA_BITS-1:0]  area;
      logic [AREA_BITS-1:0]  den;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: sv/ror_front.sv
// Front end: accepts box pairs, intersects them, classifies and forms the two areas.
module ror_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ror_pkg::req_word_type     req_payload,
   input  ror_pkg::queue_status_type q_status,
   output logic                      push,
   output ror_pkg::job_type          push_word
);

   localparam int C = ror_pkg::COORD_BITS;
   localparam int A = ror_pkg::AREA_BITS;

   typedef struct packed {
      logic         hit;
      logic [C-1:0] start;
      logic [C-1:0] len;
   } span_type;

   // Closed spans [s, s+l]; sums carry one extra bit so nothing wraps.
   function automatic span_type span_meet(input logic [C-1:0] s1, input logic [C-1:0] l1,
                                          input logic [C-1:0] s2, input logic [C-1:0] l2);
      logic [C:0] e1;
      logic [C:0] e2;
      logic [C:0] lo;
      logic [C:0] hi;
      logic [C:0] diff;
      span_type   r;
      e1 = {1'b0, s1} + {1'b0, l1};
      e2 = {1'b0, s2} + {1'b0, l2};
      lo = (s1 > s2) ? {1'b0, s1} : {1'b0, s2};
      hi = (e1 < e2) ? e1 : e2;
      diff = hi - lo;
      r.hit = !((e1 < {1'b0, s2}) || ({1'b0, s1} > e2));
      r.start = lo[C-1:0];
      r.len = diff[C-1:0];
      return r;
   endfunction

   logic                   front_en;
   span_type               span_x;
   span_type               span_y;
   logic                   meet_hit;
   logic                   first_empty;

   logic                   a_vld_ff;
   logic [C-1:0]           a_ml_ff, a_mt_ff, a_mw_ff, a_mh_ff, a_fw_ff, a_fh_ff;
   ror_pkg::ratio_sel_type a_sel_ff;
   ror_pkg::ratio_sel_type a_sel_in;

   logic                   b_vld_ff;
   ror_pkg::job_type       b_job_ff;
   ror_pkg::job_type       b_job_in;

   assign front_en  = !b_vld_ff || !q_status.full;
   assign req_stall = !front_en;
   assign push      = b_vld_ff && !q_status.full;
   assign push_word = b_job_ff;

   always_comb begin
      span_x = span_meet(req_payload.first_left, req_payload.first_width,
                         req_payload.second_left, req_payload.second_width);
      span_y = span_meet(req_payload.first_top, req_payload.first_height,
                         req_payload.second_top, req_payload.second_height);
      meet_hit = span_x.hit && span_y.hit;
      first_empty = (req_payload.first_width == '0) || (req_payload.first_height == '0);
      // an empty second box needs no case: its meet span is already zero
      unique case ({first_empty, req_payload.mode})
         2'b10:   a_sel_in = ror_pkg::RATIO_FORCE_ONE;
         2'b11:   a_sel_in = ror_pkg::RATIO_FORCE_ZERO;
         default: a_sel_in = ror_pkg::RATIO_DIVIDE;
      endcase
   end

   always_comb begin
      b_job_in.meet_left   = a_ml_ff;
      b_job_in.meet_top    = a_mt_ff;
      b_job_in.meet_width  = a_mw_ff;
      b_job_in.meet_height = a_mh_ff;
      b_job_in.sel         = a_sel_ff;
      b_job_in.area        = A'(a_mw_ff) * A'(a_mh_ff);
      b_job_in.den         = A'(a_fw_ff) * A'(a_fh_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else if (front_en) begin
         a_vld_ff <= req_valid;
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         a_ml_ff  <= meet_hit ? span_x.start : '0;
         a_mt_ff  <= meet_hit ? span_y.start : '0;
         a_mw_ff  <= meet_hit ? span_x.len : '0;
         a_mh_ff  <= meet_hit ? span_y.len : '0;
         a_fw_ff  <= req_payload.first_width;
         a_fh_ff  <= req_payload.first_height;
         a_sel_ff <= a_sel_in;
         b_job_ff <= b_job_in;
      end
   end

endmodule

FILE: sv/ror_queue.sv
// Short FIFO of classified words between the front end and the divider.
module ror_queue #(
   parameter int DEPTH = ror_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ror_pkg::job_type          push_word,
   input  logic                      pop,
   output ror_pkg::job_type          pop_word,
   output ror_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ror_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign pop_word     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

FILE: sv/ror_back.sv
// Back end: pipelined restoring divider, one quotient bit per stage, and output register.
module ror_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ror_pkg::queue_status_type q_status,
   output logic                      pop,
   input  ror_pkg::job_type          pop_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ror_pkg::rsp_word_type     rsp_payload
);

   localparam int C     = ror_pkg::COORD_BITS;
   localparam int A     = ror_pkg::AREA_BITS;
   localparam int R     = ror_pkg::RATIO_BITS;
   localparam int NSTEP = R;

   typedef struct packed {
      logic [C-1:0]           meet_left;
      logic [C-1:0]           meet_top;
      logic [C-1:0]           meet_width;
      logic [C-1:0]           meet_height;
      ror_pkg::ratio_sel_type sel;
      logic [A:0]             rem;
      logic [A-1:0]           den;
      logic [R-1:0]           quo;
   } div_stage_type;

   // area <= den, so the first bit is the integer bit and rem stays below den after it
   function automatic div_stage_type div_step(input div_stage_type s);
      logic          geq;
      logic [A:0]    diff;
      div_stage_type r;
      geq  = (s.rem >= {1'b0, s.den});
      diff = geq ? (s.rem - {1'b0, s.den}) : s.rem;
      r     = s;
      r.quo = {s.quo[R-2:0], geq};
      r.rem = {diff[A-1:0], 1'b0};
      return r;
   endfunction

   logic                  back_en;
   div_stage_type         stg_ff  [NSTEP];
   logic                  stg_vld_ff [NSTEP];
   div_stage_type         stg_in  [NSTEP];
   div_stage_type         fin;
   logic                  rsp_valid_ff;
   ror_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   assign back_en     = !rsp_valid_ff || !rsp_stall;
   assign pop         = back_en && !q_status.empty;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_word_ff;

   always_comb begin
      stg_in[0].meet_left   = pop_word.meet_left;
      stg_in[0].meet_top    = pop_word.meet_top;
      stg_in[0].meet_width  = pop_word.meet_width;
      stg_in[0].meet_height = pop_word.meet_height;
      stg_in[0].sel         = pop_word.sel;
      stg_in[0].rem         = {1'b0, pop_word.area};
      stg_in[0].den         = pop_word.den;
      stg_in[0].quo         = '0;
      for (int k = 1; k < NSTEP; k++) begin
         stg_in[k] = div_step(stg_ff[k-1]);
      end
      fin = div_step(stg_ff[NSTEP-1]);
   end

   always_comb begin
      rsp_word_in.meet_left   = fin.meet_left;
      rsp_word_in.meet_top    = fin.meet_top;
      rsp_word_in.meet_width  = fin.meet_width;
      rsp_word_in.meet_height = fin.meet_height;
      unique case (fin.sel)
         ror_pkg::RATIO_DIVIDE:    rsp_word_in.area_ratio = fin.quo;
         ror_pkg::RATIO_FORCE_ONE: rsp_word_in.area_ratio = ror_pkg::RATIO_ONE_FIXED;
         default:                  rsp_word_in.area_ratio = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTEP; k++) begin
            stg_vld_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (back_en) begin
         stg_vld_ff[0] <= pop;
         for (int k = 1; k < NSTEP; k++) begin
            stg_vld_ff[k] <= stg_vld_ff[k-1];
         end
         rsp_valid_ff <= stg_vld_ff[NSTEP-1];
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         for (int k = 0; k < NSTEP; k++) begin
            stg_ff[k] <= stg_in[k];
         end
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

FILE: sv/rect_overlap_ratio.sv
// Rectangle overlap ratio: takes one box pair per clock and returns the
// intersection box and the intersection area over the first box's area as
// unsigned 1.16 fixed point, truncated. A word is accepted every cycle while
// the output is not stalled. Each word passes the front end's intersect and
// multiply registers, then the queue, then the divider, which resolves one
// quotient bit per pipeline stage; the output register follows.
// The queue between front end and divider lets the input keep flowing for
// QUEUE_DEPTH words while the output is stalled.
module rect_overlap_ratio #(
   parameter int QUEUE_DEPTH = ror_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ror_pkg::req_word_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ror_pkg::rsp_word_type rsp_payload
);

   logic                      push;
   logic                      pop;
   ror_pkg::job_type          push_word;
   ror_pkg::job_type          pop_word;
   ror_pkg::queue_status_type q_status;

   ror_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .push_word   (push_word)
   );

   ror_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .pop_word  (pop_word),
      .status    (q_status)
   );

   ror_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .pop         (pop),
      .pop_word    (pop_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   a_ratio_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.area_ratio <= ror_pkg::RATIO_ONE_FIXED))
      else $error("area_ratio above 1.0");

   a_empty_meet_ratio: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.meet_width == '0)) |->
         ((rsp_payload.area_ratio == '0) ||
          (rsp_payload.area_ratio == ror_pkg::RATIO_ONE_FIXED)))
      else $error("zero-width intersection with fractional ratio");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("divider took a word from an empty queue");

   a_push_nonfull: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> !($past(q_status.full)))
      else $error("front end wrote into a full queue");

endmodule

FILE: test/rect_overlap_ratio_tb.sv
// Self-checking testbench for the rectangle overlap ratio block.
module rect_overlap_ratio_tb;
   import ror_pkg::*;

   localparam logic MODE_CONTAIN   = 1'b0;
   localparam logic MODE_SAME_SIZE = 1'b1;
   localparam int   COORD_MAX      = (1 << COORD_BITS) - 1;
   localparam int   RANDOM_PAIRS   = 530;
   localparam int   SETTLE_CYCLES  = 40;
   localparam int   CYCLE_LIMIT    = 400000;

   typedef struct {
      bit           drain_first;
      req_word_type word;
   } queued_pair_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_payload;

   queued_pair_type pair_backlog[$];
   rsp_word_type    expected_meet[$];
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              burst_left = 0;
   int              gap_left = 0;
   int              stall_phase_left = 0;
   int              stall_pct = 0;

   rect_overlap_ratio dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   // Intersection box and area share of the first box, spans taken as [s, s+len].
   function automatic rsp_word_type predict_overlap(req_word_type w);
      logic [COORD_BITS:0] first_right, first_bottom, second_right, second_bottom;
      logic [COORD_BITS:0] lo_x, lo_y, hi_x, hi_y;
      logic                apart;
      longint unsigned     num, den, quot;
      rsp_word_type        r;
      first_right   = {1'b0, w.first_left}  + {1'b0, w.first_width};
      first_bottom  = {1'b0, w.first_top}   + {1'b0, w.first_height};
      second_right  = {1'b0, w.second_left} + {1'b0, w.second_width};
      second_bottom = {1'b0, w.second_top}  + {1'b0, w.second_height};
      apart = (first_right < {1'b0, w.second_left}) || ({1'b0, w.first_left} > second_right)
           || (first_bottom < {1'b0, w.second_top}) || ({1'b0, w.first_top} > second_bottom);
      r = '0;
      if (!apart) begin
         lo_x = (w.first_left > w.second_left) ? {1'b0, w.first_left} : {1'b0, w.second_left};
         lo_y = (w.first_top > w.second_top) ? {1'b0, w.first_top} : {1'b0, w.second_top};
         hi_x = (first_right < second_right) ? first_right : second_right;
         hi_y = (first_bottom < second_bottom) ? first_bottom : second_bottom;
         r.meet_left   = lo_x[COORD_BITS-1:0];
         r.meet_top    = lo_y[COORD_BITS-1:0];
         r.meet_width  = COORD_BITS'(hi_x - lo_x);
         r.meet_height = COORD_BITS'(hi_y - lo_y);
      end
      if (w.first_width == 0 || w.first_height == 0) begin
         r.area_ratio = (w.mode == MODE_CONTAIN) ? RATIO_ONE_FIXED : '0;
      end else if (w.mode == MODE_CONTAIN && (w.second_width == 0 || w.second_height == 0)) begin
         r.area_ratio = '0;
      end else begin
         num  = (longint'(r.meet_width) * longint'(r.meet_height)) << FRAC_BITS;
         den  = longint'(w.first_width) * longint'(w.first_height);
         quot = num / den;
         if (quot > longint'(RATIO_ONE_FIXED))
            quot = longint'(RATIO_ONE_FIXED);
         r.area_ratio = RATIO_BITS'(quot);
      end
      return r;
   endfunction

   function automatic req_word_type make_pair(logic m, int fl, int ft, int fw, int fh,
                                              int sl, int st, int sw, int sh);
      req_word_type w;
      w.mode          = m;
      w.first_left    = COORD_BITS'(fl);
      w.first_top     = COORD_BITS'(ft);
      w.first_width   = COORD_BITS'(fw);
      w.first_height  = COORD_BITS'(fh);
      w.second_left   = COORD_BITS'(sl);
      w.second_top    = COORD_BITS'(st);
      w.second_width  = COORD_BITS'(sw);
      w.second_height = COORD_BITS'(sh);
      return w;
   endfunction

   // Mostly pairs placed near each other so they overlap, touch or just miss.
   function automatic req_word_type random_pair();
      req_word_type w;
      int           kind, lim, pos;
      kind = $urandom_range(0, 9);
      w.mode          = 1'($urandom);
      w.first_left    = COORD_BITS'($urandom);
      w.first_top     = COORD_BITS'($urandom);
      w.first_width   = COORD_BITS'($urandom);
      w.first_height  = COORD_BITS'($urandom);
      w.second_left   = COORD_BITS'($urandom);
      w.second_top    = COORD_BITS'($urandom);
      w.second_width  = COORD_BITS'($urandom);
      w.second_height = COORD_BITS'($urandom);
      if (kind != 0) begin
         lim = (kind < 6) ? 63 : ((kind < 9) ? 1023 : COORD_MAX);
         w.first_width   = COORD_BITS'($urandom_range(0, lim));
         w.first_height  = COORD_BITS'($urandom_range(0, lim));
         w.second_width  = COORD_BITS'($urandom_range(0, lim));
         w.second_height = COORD_BITS'($urandom_range(0, lim));
         case ($urandom_range(0, 19))
            0: w.first_width   = '0;
            1: w.first_height  = '0;
            2: w.second_width  = '0;
            3: w.second_height = '0;
            4: begin
               w.second_width  = w.first_width;
               w.second_height = w.first_height;
            end
            default: ;
         endcase
         pos = int'(w.first_left) - int'(w.second_width) - 2
             + int'($urandom_range(0, int'(w.first_width) + int'(w.second_width) + 4));
         w.second_left = COORD_BITS'((pos < 0) ? 0 : ((pos > COORD_MAX) ? COORD_MAX : pos));
         pos = int'(w.first_top) - int'(w.second_height) - 2
             + int'($urandom_range(0, int'(w.first_height) + int'(w.second_height) + 4));
         w.second_top = COORD_BITS'((pos < 0) ? 0 : ((pos > COORD_MAX) ? COORD_MAX : pos));
      end
      return w;
   endfunction

   task automatic queue_pair(req_word_type w, bit drain_first);
      queued_pair_type q;
      q.drain_first = drain_first;
      q.word        = w;
      pair_backlog.push_back(q);
   endtask

   // Sender: bursts with gaps; a drain-marked word waits until all results are back.
   always @(posedge clock) begin : pair_driver
      queued_pair_type next_pair;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_meet.push_back(predict_overlap(req_payload));
         if (req_valid && req_stall) begin
            // hold the stalled word
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pair_backlog.size() != 0 &&
                      !(pair_backlog[0].drain_first && expected_meet.size() != 0)) begin
            next_pair   = pair_backlog.pop_front();
            req_valid   <= 1'b1;
            req_payload <= next_pair.word;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 50);
               gap_left   = $urandom_range(0, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stalls at a rate that changes from phase to phase, zero included.
   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         stall_phase_left = $urandom_range(20, 150);
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
         endcase
      end
      stall_phase_left--;
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin : result_monitor
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_meet.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result word: %p", rsp_payload);
         end else begin
            want = expected_meet.pop_front();
            if (want.meet_left !== rsp_payload.meet_left ||
                want.meet_top !== rsp_payload.meet_top ||
                want.meet_width !== rsp_payload.meet_width ||
                want.meet_height !== rsp_payload.meet_height ||
                want.area_ratio !== rsp_payload.area_ratio) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: expected box %0d %0d %0d %0d ratio %0d,",
                            " got %0d %0d %0d %0d ratio %0d"},
                           want.meet_left, want.meet_top, want.meet_width,
                           want.meet_height, want.area_ratio,
                           rsp_payload.meet_left, rsp_payload.meet_top,
                           rsp_payload.meet_width, rsp_payload.meet_height,
                           rsp_payload.area_ratio);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      // zero-sized boxes at the origin touch; empty first box
      queue_pair(make_pair(MODE_CONTAIN, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
      queue_pair(make_pair(MODE_SAME_SIZE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
      // every field at its maximum, boxes reaching past the coordinate range
      queue_pair(make_pair(MODE_CONTAIN, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095), 1'b0);
      queue_pair(make_pair(MODE_SAME_SIZE, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095), 1'b0);
      queue_pair(make_pair(MODE_CONTAIN, 100, 200, 50, 60, 100, 200, 50, 60), 1'b0);
      queue_pair(make_pair(MODE_CONTAIN, 0, 0, 100, 100, 10, 10, 20, 30), 1'b0);
      // sizes differ in overlap-rate mode
      queue_pair(make_pair(MODE_SAME_SIZE, 10, 10, 20, 30, 0, 0, 100, 100), 1'b0);
      // apart on one axis only
      queue_pair(make_pair(MODE_CONTAIN, 0, 0, 10, 10, 11, 0, 10, 10), 1'b0);
      queue_pair(make_pair(MODE_CONTAIN, 0, 0, 10, 10, 0, 11, 10, 10), 1'b0);
      queue_pair(make_pair(MODE_SAME_SIZE, 100, 100, 10, 10, 0, 100, 99, 10), 1'b0);
      // shared edge and shared corner
      queue_pair(make_pair(MODE_CONTAIN, 0, 0, 10, 10, 10, 0, 5, 10), 1'b0);
      queue_pair(make_pair(MODE_SAME_SIZE, 0, 0, 10, 10, 10, 10, 5, 5), 1'b0);
      // empty first box, then empty second box, in both modes
      queue_pair(make_pair(MODE_CONTAIN, 5, 5, 0, 10, 0, 0, 20, 20), 1'b0);
      queue_pair(make_pair(MODE_SAME_SIZE, 5, 5, 10, 0, 0, 0, 20, 20), 1'b0);
      queue_pair(make_pair(MODE_CONTAIN, 0, 0, 10, 10, 2, 2, 0, 5), 1'b0);
      queue_pair(make_pair(MODE_SAME_SIZE, 0, 0, 10, 10, 2, 2, 5, 0), 1'b0);
      queue_pair(make_pair(MODE_CONTAIN, 3, 3, 0, 0, 3, 3, 0, 0), 1'b0);
      queue_pair(make_pair(MODE_SAME_SIZE, 0, 0, 64, 64, 32, 16, 64, 64), 1'b0);
      queue_pair(make_pair(MODE_CONTAIN, 4000, 4000, 4095, 4095, 4095, 0, 4095, 4095), 1'b0);
      queue_pair(make_pair(MODE_CONTAIN, 7, 7, 1, 1, 7, 7, 1, 1), 1'b0);
      queue_pair(make_pair(MODE_SAME_SIZE, 0, 0, 4095, 1, 2048, 0, 1, 4095), 1'b0);
      queue_pair(make_pair(MODE_CONTAIN, 'hAAA, 'h555, 'hAAA, 'h555,
                           'h555, 'hAAA, 'h555, 'hAAA), 1'b0);
      queue_pair(make_pair(MODE_SAME_SIZE, 0, 0, 4095, 4095, 1000, 2000, 3, 7), 1'b0);
      for (int i = 0; i < RANDOM_PAIRS; i++)
         queue_pair(random_pair(), (i == 0) || (i == RANDOM_PAIRS / 2));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (pair_backlog.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_meet.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_meet.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
